FILE: rtl/rcsp_pkg.sv
`timescale 1ns / 1ps

package rcsp_pkg;

    localparam int SLOT_COUNT   = 32;
    localparam int COUNT_BITS   = 16;
    localparam int SLOT_W       = $clog2(SLOT_COUNT);
    localparam int FIELD_SLOT_W = 5;
    localparam int HANDLE_W     = 32;
    localparam int FUNC_W       = 2;
    localparam int STATUS_W     = 3;

    // kind, clean_all, slot_ref, slot_ref_valid, conf_handle, base_handle
    localparam int IN_FIELDS_W  = 1 + 1 + FIELD_SLOT_W + 1 + 2 * HANDLE_W;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    // slot, slot_valid, handle_conf, handle_base, record_kind, server/client set
    localparam int OUT_FIELDS_W = FIELD_SLOT_W + 1 + 2 * HANDLE_W + 1 + 1 + 1;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    typedef logic [SLOT_W-1:0]     slot_idx_t;
    typedef logic [COUNT_BITS-1:0] count_t;
    typedef logic [HANDLE_W-1:0]   handle_t;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_REGISTER = 2'd0,
        FUNC_CLEAN    = 2'd1,
        FUNC_BOOK     = 2'd2,
        FUNC_RELEASE  = 2'd3
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_REGISTERED = 3'd0,
        STATUS_FULL       = 3'd1,
        STATUS_BOOKED     = 3'd2,
        STATUS_NO_CURRENT = 3'd3,
        STATUS_RELEASED   = 3'd4,
        STATUS_FREED      = 3'd5,
        STATUS_CLEAN_DONE = 3'd6
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FREE,
        ST_FINISH,
        ST_ACCESS_READ,
        ST_ACCESS_EMIT
    } state_t;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_LATCH,
        CMD_ADVANCE,
        CMD_FREE,
        CMD_FINISH,
        CMD_ACCESS
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t op;
        logic    rd_target;
    } cmd_t;

    typedef struct packed {
        logic free_hit;
        logic scan_last;
        logic out_free;
    } stat_t;

    typedef struct packed {
        func_t                   func;
        logic                    kind;
        logic                    clean_all;
        logic [FIELD_SLOT_W-1:0] slot_ref;
        logic                    slot_ref_valid;
        handle_t                 conf_handle;
        handle_t                 base_handle;
    } item_t;

    typedef struct packed {
        status_t                 status;
        logic [FIELD_SLOT_W-1:0] slot;
        logic                    slot_valid;
        handle_t                 handle_conf;
        handle_t                 handle_base;
        logic                    record_kind;
        logic                    server_current_set;
        logic                    client_current_set;
        logic                    last;
    } result_t;

endpackage

FILE: rtl/rcsp_ctrl.sv
`timescale 1ns / 1ps

module rcsp_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   in_valid,
    input  rcsp_pkg::func_t        in_func,
    input  rcsp_pkg::stat_t        stat,
    output logic                   in_ready,
    output rcsp_pkg::cmd_t         cmd
);

    rcsp_pkg::state_t state_reg;
    rcsp_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rcsp_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        in_ready      = 1'b0;
        cmd.op        = rcsp_pkg::CMD_NONE;
        cmd.rd_target = 1'b0;
        unique case (state_reg)
            rcsp_pkg::ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.op = rcsp_pkg::CMD_LATCH;
                    if (in_func == rcsp_pkg::FUNC_REGISTER ||
                        in_func == rcsp_pkg::FUNC_CLEAN) begin
                        state_next = rcsp_pkg::ST_SCAN;
                    end else begin
                        state_next = rcsp_pkg::ST_ACCESS_READ;
                    end
                end
            end
            rcsp_pkg::ST_SCAN: begin
                // a hit first goes to ST_FREE, where the registered handle read of that slot is used
                if (stat.free_hit) begin
                    state_next = rcsp_pkg::ST_FREE;
                end else begin
                    cmd.op = rcsp_pkg::CMD_ADVANCE;
                    if (stat.scan_last) begin
                        state_next = rcsp_pkg::ST_FINISH;
                    end
                end
            end
            rcsp_pkg::ST_FREE: begin
                if (stat.out_free) begin
                    cmd.op     = rcsp_pkg::CMD_FREE;
                    state_next = stat.scan_last ? rcsp_pkg::ST_FINISH : rcsp_pkg::ST_SCAN;
                end
            end
            rcsp_pkg::ST_FINISH: begin
                if (stat.out_free) begin
                    cmd.op     = rcsp_pkg::CMD_FINISH;
                    state_next = rcsp_pkg::ST_IDLE;
                end
            end
            rcsp_pkg::ST_ACCESS_READ: begin
                cmd.rd_target = 1'b1;
                state_next    = rcsp_pkg::ST_ACCESS_EMIT;
            end
            rcsp_pkg::ST_ACCESS_EMIT: begin
                cmd.rd_target = 1'b1;
                if (stat.out_free) begin
                    cmd.op     = rcsp_pkg::CMD_ACCESS;
                    state_next = rcsp_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = rcsp_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/rcsp_datapath.sv
`timescale 1ns / 1ps

module rcsp_datapath (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  rcsp_pkg::item_t      in_item,
    input  rcsp_pkg::cmd_t       cmd,
    output rcsp_pkg::stat_t      stat,
    input  logic                 out_ready,
    output logic                 out_valid,
    output rcsp_pkg::result_t    out_result
);

    localparam int SLOTS = rcsp_pkg::SLOT_COUNT;
    localparam int SW    = rcsp_pkg::SLOT_W;
    localparam int HW    = rcsp_pkg::HANDLE_W;

    rcsp_pkg::item_t     item_q_reg;
    rcsp_pkg::slot_idx_t ptr_reg;
    rcsp_pkg::slot_idx_t found_reg;
    logic                found_valid_reg;
    logic [SLOTS-1:0]    occ_reg;
    logic [SLOTS-1:0]    kind_reg;
    logic [SLOTS-1:0]    sel_reg;
    rcsp_pkg::count_t    count_reg [SLOTS];
    rcsp_pkg::slot_idx_t srv_cur_reg;
    logic                srv_valid_reg;
    rcsp_pkg::slot_idx_t cli_cur_reg;
    logic                cli_valid_reg;

    // {base, conf} per slot
    logic [2*HW-1:0]     mem [SLOTS];
    logic [2*HW-1:0]     rdata_reg;

    logic                out_valid_reg;
    rcsp_pkg::result_t   out_result_reg;

    logic                clean_all_eff;
    logic                free_hit;
    logic                scan_last;
    logic                out_free;
    logic                load;
    logic                is_register;
    logic                is_book;
    rcsp_pkg::slot_idx_t tgt_idx;
    logic                tgt_ok;
    rcsp_pkg::slot_idx_t rd_addr;
    logic [SLOTS-1:0]    sel_new;
    rcsp_pkg::result_t   result_next;

    assign is_register   = (item_q_reg.func == rcsp_pkg::FUNC_REGISTER);
    assign is_book       = (item_q_reg.func == rcsp_pkg::FUNC_BOOK);
    assign clean_all_eff = (item_q_reg.func == rcsp_pkg::FUNC_CLEAN) && item_q_reg.clean_all;

    assign free_hit  = occ_reg[ptr_reg] &&
                       (clean_all_eff || (count_reg[ptr_reg] == '0 && !sel_reg[ptr_reg]));
    assign scan_last = (ptr_reg == SW'(SLOTS - 1));
    assign out_free  = !out_valid_reg || out_ready;
    assign load      = (cmd.op == rcsp_pkg::CMD_FREE) || (cmd.op == rcsp_pkg::CMD_FINISH) ||
                       (cmd.op == rcsp_pkg::CMD_ACCESS);

    assign stat.free_hit  = free_hit;
    assign stat.scan_last = scan_last;
    assign stat.out_free  = out_free;

    // book targets the current slot of the kind, release the named slot
    always_comb begin
        if (is_book) begin
            tgt_idx = item_q_reg.kind ? srv_cur_reg : cli_cur_reg;
            tgt_ok  = item_q_reg.kind ? srv_valid_reg : cli_valid_reg;
        end else begin
            tgt_idx = SW'(item_q_reg.slot_ref);
            tgt_ok  = item_q_reg.slot_ref_valid && (32'(item_q_reg.slot_ref) < 32'(SLOTS));
        end
    end

    assign rd_addr = cmd.rd_target ? tgt_idx : ptr_reg;

    // selected marks after a register: previous current of the kind dropped,
    // new slot marked; previous current is occupied, so never the new slot
    always_comb begin
        sel_new = sel_reg;
        if (item_q_reg.kind) begin
            if (srv_valid_reg) begin
                sel_new[srv_cur_reg] = 1'b0;
            end
        end else if (cli_valid_reg) begin
            sel_new[cli_cur_reg] = 1'b0;
        end
        sel_new[found_reg] = 1'b1;
    end

    always_comb begin
        result_next                    = '0;
        result_next.server_current_set = srv_valid_reg;
        result_next.client_current_set = cli_valid_reg;
        unique case (cmd.op)
            rcsp_pkg::CMD_FREE: begin
                result_next.status      = rcsp_pkg::STATUS_FREED;
                result_next.slot        = rcsp_pkg::FIELD_SLOT_W'(ptr_reg);
                result_next.slot_valid  = 1'b1;
                result_next.handle_conf = rdata_reg[HW-1:0];
                result_next.handle_base = rdata_reg[2*HW-1:HW];
                result_next.record_kind = kind_reg[ptr_reg];
            end
            rcsp_pkg::CMD_FINISH: begin
                result_next.last = 1'b1;
                if (!is_register) begin
                    result_next.status = rcsp_pkg::STATUS_CLEAN_DONE;
                end else if (found_valid_reg) begin
                    result_next.status      = rcsp_pkg::STATUS_REGISTERED;
                    result_next.slot        = rcsp_pkg::FIELD_SLOT_W'(found_reg);
                    result_next.slot_valid  = 1'b1;
                    result_next.handle_conf = item_q_reg.conf_handle;
                    result_next.handle_base = item_q_reg.kind ? item_q_reg.base_handle : '0;
                    result_next.record_kind = item_q_reg.kind;
                    if (item_q_reg.kind) begin
                        result_next.server_current_set = 1'b1;
                    end else begin
                        result_next.client_current_set = 1'b1;
                    end
                end else begin
                    result_next.status = rcsp_pkg::STATUS_FULL;
                end
            end
            rcsp_pkg::CMD_ACCESS: begin
                result_next.last = 1'b1;
                if (is_book) begin
                    result_next.status = tgt_ok ? rcsp_pkg::STATUS_BOOKED
                                                : rcsp_pkg::STATUS_NO_CURRENT;
                end else begin
                    result_next.status = rcsp_pkg::STATUS_RELEASED;
                end
                if (tgt_ok) begin
                    result_next.slot        = rcsp_pkg::FIELD_SLOT_W'(tgt_idx);
                    result_next.slot_valid  = 1'b1;
                    result_next.handle_conf = rdata_reg[HW-1:0];
                    result_next.handle_base = rdata_reg[2*HW-1:HW];
                    result_next.record_kind = kind_reg[tgt_idx];
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ptr_reg         <= '0;
            found_reg       <= '0;
            found_valid_reg <= 1'b0;
            occ_reg         <= '0;
            kind_reg        <= '0;
            sel_reg         <= '0;
            for (int i = 0; i < SLOTS; i++) begin
                count_reg[i] <= '0;
            end
            srv_cur_reg     <= '0;
            srv_valid_reg   <= 1'b0;
            cli_cur_reg     <= '0;
            cli_valid_reg   <= 1'b0;
            out_valid_reg   <= 1'b0;
        end else begin
            if (load) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
            unique case (cmd.op)
                rcsp_pkg::CMD_LATCH: begin
                    ptr_reg         <= '0;
                    found_valid_reg <= 1'b0;
                    if (in_item.func == rcsp_pkg::FUNC_CLEAN && in_item.clean_all) begin
                        srv_cur_reg   <= '0;
                        srv_valid_reg <= 1'b0;
                        cli_cur_reg   <= '0;
                        cli_valid_reg <= 1'b0;
                    end
                end
                rcsp_pkg::CMD_ADVANCE: begin
                    if (!occ_reg[ptr_reg] && !found_valid_reg) begin
                        found_reg       <= ptr_reg;
                        found_valid_reg <= 1'b1;
                    end
                    if (!scan_last) begin
                        ptr_reg <= ptr_reg + SW'(1);
                    end
                end
                rcsp_pkg::CMD_FREE: begin
                    occ_reg[ptr_reg]   <= 1'b0;
                    kind_reg[ptr_reg]  <= 1'b0;
                    sel_reg[ptr_reg]   <= 1'b0;
                    count_reg[ptr_reg] <= '0;
                    if (!found_valid_reg) begin
                        found_reg       <= ptr_reg;
                        found_valid_reg <= 1'b1;
                    end
                    if (!scan_last) begin
                        ptr_reg <= ptr_reg + SW'(1);
                    end
                end
                rcsp_pkg::CMD_FINISH: begin
                    if (is_register && found_valid_reg) begin
                        occ_reg[found_reg]   <= 1'b1;
                        kind_reg[found_reg]  <= item_q_reg.kind;
                        count_reg[found_reg] <= '0;
                        sel_reg              <= sel_new;
                        if (item_q_reg.kind) begin
                            srv_cur_reg   <= found_reg;
                            srv_valid_reg <= 1'b1;
                        end else begin
                            cli_cur_reg   <= found_reg;
                            cli_valid_reg <= 1'b1;
                        end
                    end
                end
                rcsp_pkg::CMD_ACCESS: begin
                    if (tgt_ok) begin
                        if (is_book) begin
                            if (count_reg[tgt_idx] != '1) begin
                                count_reg[tgt_idx] <= count_reg[tgt_idx] +
                                                      rcsp_pkg::COUNT_BITS'(1);
                            end
                        end else if (count_reg[tgt_idx] != '0) begin
                            count_reg[tgt_idx] <= count_reg[tgt_idx] -
                                                  rcsp_pkg::COUNT_BITS'(1);
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.op == rcsp_pkg::CMD_LATCH) begin
            item_q_reg <= in_item;
        end
        rdata_reg <= mem[rd_addr];
        if (cmd.op == rcsp_pkg::CMD_FREE) begin
            mem[ptr_reg] <= '0;
        end else if (cmd.op == rcsp_pkg::CMD_FINISH && is_register && found_valid_reg) begin
            mem[found_reg] <= {(item_q_reg.kind ? item_q_reg.base_handle
                                                : rcsp_pkg::handle_t'(0)),
                               item_q_reg.conf_handle};
        end
        if (load) begin
            out_result_reg <= result_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_result = out_result_reg;

`ifndef SYNTHESIS
    a_srv_current_live: assert property (@(posedge aclk) disable iff (!aresetn)
        srv_valid_reg |-> (occ_reg[srv_cur_reg] && sel_reg[srv_cur_reg]))
        else $error("server current slot not occupied and selected");

    a_cli_current_live: assert property (@(posedge aclk) disable iff (!aresetn)
        cli_valid_reg |-> (occ_reg[cli_cur_reg] && sel_reg[cli_cur_reg]))
        else $error("client current slot not occupied and selected");

    a_free_occupied: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == rcsp_pkg::CMD_FREE) |-> occ_reg[ptr_reg])
        else $error("freeing a slot that is empty");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (load && out_valid_reg) |-> out_ready)
        else $error("result register overwritten before taken");
`endif

endmodule

FILE: rtl/refcounted_context_slot_pool.sv
`timescale 1ns / 1ps

// Reference-counted pool of context slots.
// Requests enter on the s_ channel (s_tuser = func, s_tdata = payload) and
// results leave on the m_ channel (m_tuser = status, m_tlast on the final
// result of a request). Register and clean produce one "slot freed" result
// per freed slot in ascending order, then one closing result; book and
// release produce a single result.
// Timing: book and release pass through ST_ACCESS_READ and ST_ACCESS_EMIT before
// the result is registered. Register and clean walk the slot table one slot per
// cycle, with an extra ST_FREE step for each freed slot, then ST_FINISH; a full
// output register holds ST_FREE and ST_FINISH. The table walk sets the rate.
// One request is in work at a time; s_tready is high only between requests,
// but a new request is taken while the last result still sits in the output
// register. A stalled m_tready holds the output register and the walk waits
// on it; no result is dropped.
// Reset (aresetn low, synchronous) empties every slot, zeroes all counts and
// clears both current marks; it needs no clearing pass.
module refcounted_context_slot_pool (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // kind, clean_all, slot_ref[4:0], slot_ref_valid, conf_handle[31:0],
    // base_handle[31:0]
    input  logic [rcsp_pkg::IN_TDATA_W-1:0]    s_tdata,
    // func[1:0]
    input  logic [rcsp_pkg::FUNC_W-1:0]        s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // slot[4:0], slot_valid, handle_conf[31:0], handle_base[31:0], record_kind,
    // server_current_set, client_current_set, zero pad
    output logic [rcsp_pkg::OUT_TDATA_W-1:0]   m_tdata,
    // status[2:0]
    output logic [rcsp_pkg::STATUS_W-1:0]      m_tuser,
    output logic                               m_tlast
);

    localparam int HW = rcsp_pkg::HANDLE_W;
    localparam int FS = rcsp_pkg::FIELD_SLOT_W;

    rcsp_pkg::item_t   in_item;
    rcsp_pkg::cmd_t    cmd;
    rcsp_pkg::stat_t   stat;
    rcsp_pkg::result_t out_result;

    assign in_item.func           = rcsp_pkg::func_t'(s_tuser);
    assign in_item.kind           = s_tdata[0];
    assign in_item.clean_all      = s_tdata[1];
    assign in_item.slot_ref       = s_tdata[FS+1:2];
    assign in_item.slot_ref_valid = s_tdata[FS+2];
    assign in_item.conf_handle    = s_tdata[FS+2+HW:FS+3];
    assign in_item.base_handle    = s_tdata[FS+2+2*HW:FS+3+HW];

    rcsp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_func  (in_item.func),
        .stat     (stat),
        .in_ready (s_tready),
        .cmd      (cmd)
    );

    rcsp_datapath u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_item    (in_item),
        .cmd        (cmd),
        .stat       (stat),
        .out_ready  (m_tready),
        .out_valid  (m_tvalid),
        .out_result (out_result)
    );

    assign m_tuser = out_result.status;
    assign m_tlast = out_result.last;
    assign m_tdata = {{(rcsp_pkg::OUT_TDATA_W - rcsp_pkg::OUT_FIELDS_W){1'b0}},
                      out_result.client_current_set,
                      out_result.server_current_set,
                      out_result.record_kind,
                      out_result.handle_base,
                      out_result.handle_conf,
                      out_result.slot_valid,
                      out_result.slot};

endmodule
